// ===== sv/rsoe_pkg.sv =====
package rsoe_pkg;

    localparam int MAX_PAIRS_DEF = 8;
    localparam int PAIR_W = 16;
    localparam int OP_W = 3;
    localparam int CMD_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INTERSECT = 3'd0,
        OP_UNION     = 3'd1,
        OP_DIFF      = 3'd2,
        OP_SYMDIFF   = 3'd3,
        OP_INVERT    = 3'd4,
        OP_COMPOSE   = 3'd5
    } op_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2
    } cmd_t;

endpackage

// ===== sv/relation_set_operation_engine.sv =====
// channel    | dir | tdata (low bit up)             | tuser          | tlast
// s_ input   | in  | first[7:0], second[15:8]       | command[1:0]   | -
// m_ result  | out | first_out[7:0], second_out[15:8] | empty_res[0] | last
// cfg        | in  | cfg_wr_data = operation[2:0], written when cfg_wr_en is high
//
// a load scans the target set memory for a duplicate, reading and then
// comparing one entry at a time.
// a compute item walks set A: intersect/diff/symdiff scan B per element, union and
// invert copy it, and composition scans B and then the result memory (worst case
// when every candidate is new); union and symdiff then walk B, scanning A. results
// stream out one word at a time, each held until taken.
// s_tready is high only in idle: low during a load scan and from a compute item
// until its last word is taken.
// reset (synchronous, aresetn low) clears counts and the operation; memories are not cleared.
module relation_set_operation_engine
    import rsoe_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // first, second
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // first_out, second_out
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // empty_res
);

    localparam int RES_DEPTH = MAX_PAIRS * MAX_PAIRS;
    localparam int SW  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int RW  = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
    localparam int CW  = $clog2(MAX_PAIRS + 1);
    localparam int RCW = $clog2(RES_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN_RD, ST_SCAN_CMP, ST_LD_DONE,
        ST_P1_RD, ST_P1_GET, ST_P1_DEC,
        ST_C_RD, ST_C_GET, ST_C_DEC,
        ST_P2_RD, ST_P2_GET, ST_P2_DEC,
        ST_OUT_START, ST_OUT_RD, ST_OUT_GET
    } state_t;

    typedef enum logic [1:0] {SEL_A, SEL_B, SEL_R} sel_t;

    logic [PAIR_W-1:0] mem_a [MAX_PAIRS];
    logic [PAIR_W-1:0] mem_b [MAX_PAIRS];
    logic [PAIR_W-1:0] mem_r [RES_DEPTH];

    state_t            state_reg, ret_reg;
    sel_t              sel_reg;
    logic [OP_W-1:0]   op_reg;
    logic [CW-1:0]     cnt_a_reg, cnt_b_reg, i_reg, j_reg;
    logic [RCW-1:0]    res_cnt_reg, k_reg, scan_idx_reg, scan_n_reg;
    logic [PAIR_W-1:0] key_reg, akey_reg, cand_reg;
    logic              found_reg, load_b_reg;
    logic [PAIR_W-1:0] a_rdata_reg, b_rdata_reg, r_rdata_reg;
    logic [SW-1:0]     a_raddr, b_raddr;
    logic [RW-1:0]     r_raddr;
    logic [PAIR_W-1:0] sel_rdata, in_pair;
    logic              m_tvalid_reg, m_tlast_reg, m_empty_reg;
    logic [15:0]       m_tdata_reg;

    assign in_pair = {s_tdata[7:0], s_tdata[15:8]};
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_empty_reg;

    always_comb begin
        a_raddr = i_reg[SW-1:0];
        b_raddr = (state_reg == ST_C_RD) ? j_reg[SW-1:0] : i_reg[SW-1:0];
        r_raddr = k_reg[RW-1:0];
        if (state_reg == ST_SCAN_RD) begin
            a_raddr = scan_idx_reg[SW-1:0];
            b_raddr = scan_idx_reg[SW-1:0];
            r_raddr = scan_idx_reg[RW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        a_rdata_reg <= mem_a[a_raddr];
        b_rdata_reg <= mem_b[b_raddr];
        r_rdata_reg <= mem_r[r_raddr];
    end

    always_comb begin
        case (sel_reg)
            SEL_A:   sel_rdata = a_rdata_reg;
            SEL_B:   sel_rdata = b_rdata_reg;
            default: sel_rdata = r_rdata_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ret_reg      <= ST_IDLE;
            sel_reg      <= SEL_A;
            op_reg       <= OP_INTERSECT;
            cnt_a_reg    <= '0;
            cnt_b_reg    <= '0;
            res_cnt_reg  <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            scan_idx_reg <= '0;
            scan_n_reg   <= '0;
            found_reg    <= 1'b0;
            load_b_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
            m_empty_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                op_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser == CMD_LOAD_A || s_tuser == CMD_LOAD_B) begin
                            load_b_reg   <= (s_tuser == CMD_LOAD_B);
                            key_reg      <= in_pair;
                            sel_reg      <= (s_tuser == CMD_LOAD_B) ? SEL_B : SEL_A;
                            scan_n_reg   <= RCW'((s_tuser == CMD_LOAD_B) ? cnt_b_reg
                                                                         : cnt_a_reg);
                            scan_idx_reg <= '0;
                            ret_reg      <= ST_LD_DONE;
                            if (((s_tuser == CMD_LOAD_B) ? cnt_b_reg : cnt_a_reg)
                                    < CW'(MAX_PAIRS)) begin
                                state_reg <= ST_SCAN_RD;
                            end
                        end else if (s_tuser == CMD_COMPUTE) begin
                            res_cnt_reg <= '0;
                            i_reg       <= '0;
                            state_reg   <= ST_P1_RD;
                        end
                    end
                end
                ST_SCAN_RD: begin
                    if (scan_idx_reg >= scan_n_reg) begin
                        found_reg <= 1'b0;
                        state_reg <= ret_reg;
                    end else begin
                        state_reg <= ST_SCAN_CMP;
                    end
                end
                ST_SCAN_CMP: begin
                    if (sel_rdata == key_reg) begin
                        found_reg <= 1'b1;
                        state_reg <= ret_reg;
                    end else begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                        state_reg    <= ST_SCAN_RD;
                    end
                end
                ST_LD_DONE: begin
                    if (!found_reg) begin
                        if (load_b_reg) begin
                            mem_b[cnt_b_reg[SW-1:0]] <= key_reg;
                            cnt_b_reg <= cnt_b_reg + 1'b1;
                        end else begin
                            mem_a[cnt_a_reg[SW-1:0]] <= key_reg;
                            cnt_a_reg <= cnt_a_reg + 1'b1;
                        end
                    end
                    state_reg <= ST_IDLE;
                end
                ST_P1_RD: begin
                    if (i_reg >= cnt_a_reg) begin
                        i_reg     <= '0;
                        state_reg <= (op_reg == OP_UNION || op_reg == OP_SYMDIFF)
                                     ? ST_P2_RD : ST_OUT_START;
                    end else begin
                        state_reg <= ST_P1_GET;
                    end
                end
                ST_P1_GET: begin
                    akey_reg     <= a_rdata_reg;
                    key_reg      <= a_rdata_reg;
                    scan_idx_reg <= '0;
                    unique case (op_reg)
                        OP_INTERSECT, OP_DIFF, OP_SYMDIFF: begin
                            sel_reg    <= SEL_B;
                            scan_n_reg <= RCW'(cnt_b_reg);
                            ret_reg    <= ST_P1_DEC;
                            state_reg  <= ST_SCAN_RD;
                        end
                        OP_UNION, OP_INVERT: begin
                            if (res_cnt_reg < RCW'(RES_DEPTH)) begin
                                mem_r[res_cnt_reg[RW-1:0]] <= (op_reg == OP_INVERT)
                                    ? {a_rdata_reg[7:0], a_rdata_reg[15:8]} : a_rdata_reg;
                                res_cnt_reg <= res_cnt_reg + 1'b1;
                            end
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= ST_P1_RD;
                        end
                        OP_COMPOSE: begin
                            j_reg     <= '0;
                            state_reg <= ST_C_RD;
                        end
                        default: state_reg <= ST_OUT_START;
                    endcase
                end
                ST_P1_DEC: begin
                    if ((op_reg == OP_INTERSECT) == found_reg
                            && res_cnt_reg < RCW'(RES_DEPTH)) begin
                        mem_r[res_cnt_reg[RW-1:0]] <= akey_reg;
                        res_cnt_reg <= res_cnt_reg + 1'b1;
                    end
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= ST_P1_RD;
                end
                ST_C_RD: begin
                    if (j_reg >= cnt_b_reg) begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_P1_RD;
                    end else begin
                        state_reg <= ST_C_GET;
                    end
                end
                ST_C_GET: begin
                    if (akey_reg[7:0] == b_rdata_reg[15:8]) begin
                        cand_reg     <= {akey_reg[15:8], b_rdata_reg[7:0]};
                        key_reg      <= {akey_reg[15:8], b_rdata_reg[7:0]};
                        sel_reg      <= SEL_R;
                        scan_n_reg   <= res_cnt_reg;
                        scan_idx_reg <= '0;
                        ret_reg      <= ST_C_DEC;
                        state_reg    <= ST_SCAN_RD;
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_C_RD;
                    end
                end
                ST_C_DEC: begin
                    if (!found_reg && res_cnt_reg < RCW'(RES_DEPTH)) begin
                        mem_r[res_cnt_reg[RW-1:0]] <= cand_reg;
                        res_cnt_reg <= res_cnt_reg + 1'b1;
                    end
                    j_reg     <= j_reg + 1'b1;
                    state_reg <= ST_C_RD;
                end
                ST_P2_RD: begin
                    state_reg <= (i_reg >= cnt_b_reg) ? ST_OUT_START : ST_P2_GET;
                end
                ST_P2_GET: begin
                    key_reg      <= b_rdata_reg;
                    sel_reg      <= SEL_A;
                    scan_n_reg   <= RCW'(cnt_a_reg);
                    scan_idx_reg <= '0;
                    ret_reg      <= ST_P2_DEC;
                    state_reg    <= ST_SCAN_RD;
                end
                ST_P2_DEC: begin
                    if (!found_reg && res_cnt_reg < RCW'(RES_DEPTH)) begin
                        mem_r[res_cnt_reg[RW-1:0]] <= key_reg;
                        res_cnt_reg <= res_cnt_reg + 1'b1;
                    end
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= ST_P2_RD;
                end
                ST_OUT_START: begin
                    cnt_a_reg <= '0;
                    cnt_b_reg <= '0;
                    k_reg     <= '0;
                    if (res_cnt_reg == '0) begin
                        m_tdata_reg  <= '0;
                        m_tlast_reg  <= 1'b1;
                        m_empty_reg  <= 1'b1;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_OUT_GET;
                    end else begin
                        state_reg <= ST_OUT_RD;
                    end
                end
                ST_OUT_RD: begin
                    state_reg <= ST_OUT_GET;
                end
                ST_OUT_GET: begin
                    if (!m_tvalid_reg) begin
                        m_tdata_reg  <= {r_rdata_reg[7:0], r_rdata_reg[15:8]};
                        m_tlast_reg  <= (k_reg + 1'b1 == res_cnt_reg);
                        m_empty_reg  <= 1'b0;
                        m_tvalid_reg <= 1'b1;
                    end else if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        k_reg        <= k_reg + 1'b1;
                        state_reg    <= m_tlast_reg ? ST_IDLE : ST_OUT_RD;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_a_reg <= CW'(MAX_PAIRS) && cnt_b_reg <= CW'(MAX_PAIRS))
        else $error("set count beyond capacity");
    a_empty_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && m_tdata == '0)
        else $error("empty result malformed");
    a_back_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready && cnt_a_reg == '0)
        else $error("not idle after last word");
`endif

endmodule
